@@ sv/ils_pkg.sv @@
// Shared types, codes and constants for the indexed list store.
`timescale 1ns / 1ps

package ils_pkg;

   localparam int unsigned OP_W         = 3;
   localparam int unsigned POS_W        = 8;
   localparam int unsigned DATA_W       = 32;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned COUNT_W      = 7;
   localparam int unsigned CAPACITY_DEF = 64;

   localparam logic [OP_W-1:0] OP_GET       = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD_HEAD  = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD_TAIL  = 3'd2;
   localparam logic [OP_W-1:0] OP_ADD_INDEX = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   localparam logic signed [DATA_W-1:0] NO_VALUE = -32'sd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SHIFT,
      ST_DRAIN,
      ST_PUT,
      ST_FINISH
   } ils_state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic shift_start;
      logic shift_read;
      logic get_read;
      logic write_new;
      logic finish;
   } ils_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic get_ok;
      logic ins_ok;
      logic del_ok;
      logic is_insert;
      logic need_shift;
      logic last_step;
      logic out_free;
   } ils_stat_type;

endpackage

@@ sv/ils_if.sv @@
// Request and response channel interfaces for the indexed list store.
`timescale 1ns / 1ps

interface ils_req_if;
   logic                                valid;
   logic                                ready;
   logic [ils_pkg::OP_W-1:0]            op;
   logic [ils_pkg::POS_W-1:0]           position;
   logic signed [ils_pkg::DATA_W-1:0]   value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ils_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ils_pkg::DATA_W-1:0]   read_value;
   logic [ils_pkg::STATUS_W-1:0]        status;
   logic [ils_pkg::COUNT_W-1:0]         count;

   modport source (output valid, output read_value, output status, output count, input ready);
   modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

@@ sv/ils_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module ils_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ils_ctrl.sv @@
// Controller state machine for the indexed list store.
`timescale 1ns / 1ps

module ils_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ils_pkg::ils_stat_type stat,
   output ils_pkg::ils_cmd_type  cmd
);

   ils_pkg::ils_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ils_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ils_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ils_pkg::ST_CHECK;
            end
         end
         ils_pkg::ST_CHECK: begin
            priority if (stat.get_ok) begin
               cmd.get_read = 1'b1;
               state_in     = ils_pkg::ST_FINISH;
            end else if ((stat.ins_ok || stat.del_ok) && stat.need_shift) begin
               cmd.shift_start = 1'b1;
               state_in        = ils_pkg::ST_SHIFT;
            end else if (stat.ins_ok) begin
               state_in = ils_pkg::ST_PUT;
            end else begin
               state_in = ils_pkg::ST_FINISH;
            end
         end
         ils_pkg::ST_SHIFT: begin
            cmd.shift_read = 1'b1;
            if (stat.last_step) begin
               state_in = ils_pkg::ST_DRAIN;
            end
         end
         ils_pkg::ST_DRAIN: begin
            // last moved element is written this cycle
            state_in = stat.is_insert ? ils_pkg::ST_PUT : ils_pkg::ST_FINISH;
         end
         ils_pkg::ST_PUT: begin
            cmd.write_new = 1'b1;
            state_in      = ils_pkg::ST_FINISH;
         end
         ils_pkg::ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ils_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ils_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/ils_dpath.sv @@
// Datapath: request registers, length, shift counter, element RAM, response register.
`timescale 1ns / 1ps

module ils_dpath #(
   parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [ils_pkg::OP_W-1:0]             req_op,
   input  logic [ils_pkg::POS_W-1:0]            req_position,
   input  logic signed [ils_pkg::DATA_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ils_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [ils_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ils_pkg::COUNT_W-1:0]          rsp_count,
   input  ils_pkg::ils_cmd_type                 cmd,
   output ils_pkg::ils_stat_type                stat
);

   localparam int unsigned ADDR_W = $clog2(CAPACITY);
   localparam int unsigned LEN_W  = $clog2(CAPACITY + 1);
   // wide enough for length and position plus one
   localparam int unsigned CMP_W  =
      ((LEN_W > ils_pkg::POS_W) ? LEN_W : ils_pkg::POS_W) + 1;

   logic [ils_pkg::OP_W-1:0]          op_ff;
   logic [ils_pkg::POS_W-1:0]         pos_ff;
   logic signed [ils_pkg::DATA_W-1:0] value_ff;
   logic [LEN_W-1:0]                  len_ff, len_in;
   logic [ADDR_W-1:0]                 rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0]                 wr_addr_ff, wr_addr_in;
   logic                              wr_pend_ff;

   logic                              rsp_valid_ff;
   logic signed [ils_pkg::DATA_W-1:0] rsp_read_value_ff;
   logic [ils_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [ils_pkg::COUNT_W-1:0]       rsp_count_ff;

   logic [CMP_W-1:0] len_ext, pos_ext, ins_pos_ext, first_ext, last_ext, new_len_ext;
   logic             is_get, is_ins, is_del;
   logic             get_idx_ok, ins_idx_ok, del_idx_ok, full;
   logic [ils_pkg::STATUS_W-1:0] status;
   logic [ADDR_W-1:0] ins_addr, first_addr, last_addr;

   logic                      ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]         ram_wr_addr, ram_rd_addr;
   logic [ils_pkg::DATA_W-1:0] ram_wr_data, ram_rd_data;

   // ---- decode and checks ----
   always_comb begin
      len_ext = CMP_W'(len_ff);
      pos_ext = CMP_W'(pos_ff);
      is_get  = (op_ff == ils_pkg::OP_GET);
      is_del  = (op_ff == ils_pkg::OP_DELETE);
      is_ins  = (op_ff == ils_pkg::OP_ADD_HEAD) || (op_ff == ils_pkg::OP_ADD_TAIL) ||
                (op_ff == ils_pkg::OP_ADD_INDEX);
      priority case (op_ff)
         ils_pkg::OP_ADD_HEAD: ins_pos_ext = '0;
         ils_pkg::OP_ADD_TAIL: ins_pos_ext = len_ext;
         default:              ins_pos_ext = pos_ext;
      endcase
      get_idx_ok = (pos_ext < len_ext);
      del_idx_ok = (pos_ext < len_ext);
      ins_idx_ok = (ins_pos_ext <= len_ext);
      full       = (len_ext == CMP_W'(CAPACITY));

      if (is_get) begin
         status = get_idx_ok ? ils_pkg::ST_OK : ils_pkg::ST_BAD_INDEX;
      end else if (is_ins) begin
         priority if (!ins_idx_ok) status = ils_pkg::ST_BAD_INDEX;
         else if (full)            status = ils_pkg::ST_FULL;
         else                      status = ils_pkg::ST_OK;
      end else if (is_del) begin
         status = del_idx_ok ? ils_pkg::ST_OK : ils_pkg::ST_BAD_INDEX;
      end else begin
         status = ils_pkg::ST_BAD_INDEX;
      end

      // insert moves len-1 down to pos up by one; delete moves pos+1 up to len-1 down
      first_ext  = is_ins ? (len_ext - CMP_W'(1)) : (pos_ext + CMP_W'(1));
      last_ext   = is_ins ? ins_pos_ext : (len_ext - CMP_W'(1));
      first_addr = first_ext[ADDR_W-1:0];
      last_addr  = last_ext[ADDR_W-1:0];
      ins_addr   = ins_pos_ext[ADDR_W-1:0];

      stat.get_ok     = is_get && get_idx_ok;
      stat.ins_ok     = is_ins && ins_idx_ok && !full;
      stat.del_ok     = is_del && del_idx_ok;
      stat.is_insert  = is_ins;
      stat.need_shift = is_ins ? (ins_pos_ext < len_ext)
                               : ((pos_ext + CMP_W'(1)) < len_ext);
      stat.last_step  = (rd_idx_ff == last_addr);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // ---- length after this request ----
   always_comb begin
      len_in = len_ff;
      if (status == ils_pkg::ST_OK) begin
         if (is_ins) begin
            len_in = len_ff + LEN_W'(1);
         end else if (is_del) begin
            len_in = len_ff - LEN_W'(1);
         end
      end
      new_len_ext = CMP_W'(len_in);
   end

   // ---- shift counters ----
   always_comb begin
      rd_idx_in  = rd_idx_ff;
      wr_addr_in = wr_addr_ff;
      if (cmd.shift_start) begin
         rd_idx_in = first_addr;
      end else if (cmd.shift_read) begin
         rd_idx_in  = is_ins ? (rd_idx_ff - ADDR_W'(1)) : (rd_idx_ff + ADDR_W'(1));
         wr_addr_in = is_ins ? (rd_idx_ff + ADDR_W'(1)) : (rd_idx_ff - ADDR_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.shift_read;
         if (cmd.finish) begin
            len_ff       <= len_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      wr_addr_ff <= wr_addr_in;
      if (cmd.capture) begin
         op_ff    <= req_op;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (cmd.finish) begin
         rsp_read_value_ff <= stat.get_ok ? $signed(ram_rd_data) : ils_pkg::NO_VALUE;
         rsp_status_ff     <= status;
         rsp_count_ff      <= new_len_ext[ils_pkg::COUNT_W-1:0];
      end
   end

   // ---- element store ----
   always_comb begin
      ram_rd_en   = cmd.get_read || cmd.shift_read;
      ram_rd_addr = cmd.get_read ? pos_ext[ADDR_W-1:0] : rd_idx_ff;
      ram_wr_en   = cmd.write_new || wr_pend_ff;
      ram_wr_addr = cmd.write_new ? ins_addr : wr_addr_ff;
      ram_wr_data = cmd.write_new ? value_ff : ram_rd_data;
   end

   ils_ram #(
      .WIDTH (ils_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

@@ sv/indexed_list_store.sv @@
// Sequence per request: check, then for an insert or delete that moves m elements a shift sweep,
// then for an insert the new-element write, then the response load (m = elements moved: up to
// length on insert, length-1 on delete; one per cycle through the RAM ports).
// Throughput: one request in flight, next accepted the cycle after the response is loaded;
// the next is taken while a response waits in the output register.
// Reset (synchronous, active high) empties the list; RAM contents are not cleared.
`timescale 1ns / 1ps

module indexed_list_store #(
   parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF
) (
   input  logic  clock,
   input  logic  reset,
   ils_req_if.sink   req_chan,
   ils_rsp_if.source rsp_chan
);

   // controller <-> datapath handshake bundles
   ils_pkg::ils_cmd_type  cmd;
   ils_pkg::ils_stat_type stat;

   // sequencer: check, optional shift sweep, new-element write, response load
   ils_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, length and response register
   ils_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_chan.op),
      .req_position   (req_chan.position),
      .req_value      (req_chan.value),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_read_value (rsp_chan.read_value),
      .rsp_status     (rsp_chan.status),
      .rsp_count      (rsp_chan.count),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for indexed_list_store: random and directed list operations.
`timescale 1ns / 1ps

module tb_top;
   import ils_pkg::*;

   localparam int unsigned LIST_CAP    = CAPACITY_DEF;
   localparam int unsigned CYCLE_LIMIT = 500_000;
   localparam int unsigned RAND_OPS    = 1050;
   // Codes past the last defined operation; the block must reject them.
   localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;
   // Long receiver hold-off: HOLD_AFTER is the reply count at which it starts, HOLD_CYCLES sets how long it lasts.
   localparam int unsigned HOLD_AFTER  = 300;
   localparam int unsigned HOLD_CYCLES = 80;
   // Range of reply counts in which neither side idles.
   localparam int unsigned CALM_FROM   = 600;
   localparam int unsigned CALM_TO     = 800;
   // Cycles to wait after the last reply.
   localparam int unsigned TAIL_WAIT   = 150;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
      logic                     drain_first;   // wait for all replies before offering
   } list_op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
   } list_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ils_req_if req_bus ();
   ils_rsp_if rsp_bus ();

   indexed_list_store #(.CAPACITY(LIST_CAP)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   list_op_type    queued_ops[$];
   list_reply_type predicted_replies[$];

   // mirror of the list contents, updated as each request is accepted
   logic signed [DATA_W-1:0] mirror_elems [LIST_CAP];
   int unsigned              mirror_len = 0;

   int unsigned cycle_count  = 0;
   int unsigned replies_seen = 0;
   int unsigned mismatches   = 0;
   int unsigned rcv_hold_left = 0;
   bit          rcv_hold_done = 1'b0;

   // length as seen while generating stimulus, to aim positions at valid slots
   int unsigned gen_len = 0;

   function automatic logic [STATUS_W-1:0] mirror_insert(int unsigned at,
                                                         logic signed [DATA_W-1:0] v);
      // index check wins over the full check
      if (at > mirror_len) return ST_BAD_INDEX;
      if (mirror_len >= LIST_CAP) return ST_FULL;
      for (int unsigned i = mirror_len; i > at; i--) mirror_elems[i] = mirror_elems[i-1];
      mirror_elems[at] = v;
      mirror_len++;
      return ST_OK;
   endfunction

   function automatic logic [STATUS_W-1:0] mirror_delete(int unsigned at);
      if (at >= mirror_len) return ST_BAD_INDEX;
      for (int unsigned i = at; i + 1 < mirror_len; i++) mirror_elems[i] = mirror_elems[i+1];
      mirror_len--;
      return ST_OK;
   endfunction

   function automatic list_reply_type apply_list_op(logic [OP_W-1:0] op,
                                                    logic [POS_W-1:0] position,
                                                    logic signed [DATA_W-1:0] value);
      list_reply_type r;
      r.read_value = NO_VALUE;
      case (op)
         OP_GET: begin
            if (position < mirror_len) begin
               r.read_value = mirror_elems[position];
               r.status     = ST_OK;
            end else begin
               r.status = ST_BAD_INDEX;
            end
         end
         OP_ADD_HEAD:  r.status = mirror_insert(0, value);
         OP_ADD_TAIL:  r.status = mirror_insert(mirror_len, value);
         OP_ADD_INDEX: r.status = mirror_insert(position, value);
         OP_DELETE:    r.status = mirror_delete(position);
         default:      r.status = ST_BAD_INDEX;
      endcase
      r.count = COUNT_W'(mirror_len);
      return r;
   endfunction

   function automatic bit in_calm_window();
      return replies_seen >= CALM_FROM && replies_seen < CALM_TO;
   endfunction

   task automatic queue_op(logic [OP_W-1:0] op, logic [POS_W-1:0] position,
                           logic signed [DATA_W-1:0] value, logic drain_first);
      list_op_type item;
      item.op          = op;
      item.position    = position;
      item.value       = value;
      item.drain_first = drain_first;
      queued_ops.push_back(item);
      // track length only, so generated positions land in range
      case (op)
         OP_ADD_HEAD, OP_ADD_TAIL: if (gen_len < LIST_CAP) gen_len++;
         OP_ADD_INDEX: if (position <= gen_len && gen_len < LIST_CAP) gen_len++;
         OP_DELETE: if (position < gen_len) gen_len--;
         default: ;
      endcase
   endtask

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Request driver: predicts on acceptance, then offers the next queued request.
   always @(posedge clock) begin
      list_op_type nxt;
      bit          gap;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted_replies.push_back(apply_list_op(req_bus.op, req_bus.position,
                                                      req_bus.value));
         end
         if (!req_bus.valid || req_bus.ready) begin
            gap = !in_calm_window() && ($urandom_range(0, 99) < 7);
            if (queued_ops.size() > 0 && !gap &&
                !(queued_ops[0].drain_first && predicted_replies.size() > 0)) begin
               nxt = queued_ops.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.op       <= nxt.op;
               req_bus.position <= nxt.position;
               req_bus.value    <= nxt.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Reply monitor: checks each reply against the oldest prediction, drives ready.
   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            replies_seen++;
            if (predicted_replies.size() == 0) begin
               mismatches++;
               $display("%0t: reply with none pending: read_value %0d status %0d count %0d",
                        $time, rsp_bus.read_value, rsp_bus.status, rsp_bus.count);
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_bus.read_value !== want.read_value) begin
                  mismatches++;
                  $display("%0t: read_value expected %0d actual %0d",
                           $time, want.read_value, rsp_bus.read_value);
               end
               if (rsp_bus.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_bus.status);
               end
               if (rsp_bus.count !== want.count) begin
                  mismatches++;
                  $display("%0t: count expected %0d actual %0d",
                           $time, want.count, rsp_bus.count);
               end
            end
         end
         // one long hold-off so the block backs up and stalls its input
         if (rcv_hold_left > 0) begin
            rcv_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!rcv_hold_done && replies_seen >= HOLD_AFTER) begin
            rcv_hold_done = 1'b1;
            rcv_hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= in_calm_window() || ($urandom_range(0, 99) >= 7);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int unsigned              roll;
      int unsigned              phase;
      int unsigned              t_get, t_head, t_tail, t_idx;
      logic [OP_W-1:0]          op;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] val;

      req_bus.valid    = 1'b0;
      req_bus.op       = OP_GET;
      req_bus.position = '0;
      req_bus.value    = '0;
      rsp_bus.ready    = 1'b0;

      // Directed: empty list, extremes, append at length, bad indexes, unused codes.
      queue_op(OP_GET,       8'd0,   32'sd0, 1'b0);   // get on empty list
      queue_op(OP_DELETE,    8'd0,   32'sd0, 1'b0);   // delete on empty list
      queue_op(OP_ADD_INDEX, 8'd1,   32'sd7, 1'b0);   // insert past the end
      queue_op(OP_ADD_INDEX, 8'd0,   32'sh7fffffff, 1'b0);
      queue_op(OP_ADD_HEAD,  8'd255, 32'sh80000000, 1'b0);   // position ignored
      queue_op(OP_ADD_TAIL,  8'd255, 32'sd0, 1'b0);
      queue_op(OP_ADD_INDEX, 8'd3,   -32'sd1, 1'b0);  // position == length appends
      queue_op(OP_ADD_INDEX, 8'd1,   32'sh5a5a5a5a, 1'b0);
      queue_op(OP_GET,       8'd0,   32'sd0, 1'b0);
      queue_op(OP_GET,       8'd4,   32'sd0, 1'b0);   // last element
      queue_op(OP_GET,       8'd5,   32'sd0, 1'b0);   // position == length
      queue_op(OP_GET,       8'd255, 32'sd0, 1'b0);
      queue_op(OP_DELETE,    8'd255, 32'sd0, 1'b0);
      queue_op(OP_ADD_INDEX, 8'd255, 32'sh0f0f0f0f, 1'b0);
      queue_op(OP_UNUSED_LO, 8'd0,   32'sd1, 1'b0);
      queue_op(OP_UNUSED_MID, 8'd255, 32'sh12345678, 1'b0);
      queue_op(OP_UNUSED_HI, 8'd170, -32'sd1, 1'b0);
      queue_op(OP_DELETE,    8'd0,   32'sd0, 1'b0);   // delete front
      queue_op(OP_DELETE,    8'd3,   32'sd0, 1'b0);   // delete last
      queue_op(OP_DELETE,    8'd1,   32'sd0, 1'b0);   // delete middle
      queue_op(OP_GET,       8'd1,   32'sd0, 1'b0);
      queue_op(OP_GET,       8'd0,   32'sd0, 1'b1);   // sender waits for all replies

      // Random: phases that grow the list to full, shrink it, then mix.
      for (int unsigned k = 0; k < RAND_OPS; k++) begin
         phase = (k / 150) % 3;
         case (phase)
            0:       begin t_get = 18; t_head = 40; t_tail = 60; t_idx = 85; end
            1:       begin t_get = 18; t_head = 25; t_tail = 32; t_idx = 45; end
            default: begin t_get = 28; t_head = 42; t_tail = 56; t_idx = 76; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 3)           op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         else if (roll < t_get)  op = OP_GET;
         else if (roll < t_head) op = OP_ADD_HEAD;
         else if (roll < t_tail) op = OP_ADD_TAIL;
         else if (roll < t_idx)  op = OP_ADD_INDEX;
         else                    op = OP_DELETE;

         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            pos = POS_W'($urandom);                  // noise
         end else if (op == OP_ADD_INDEX) begin
            if (gen_len == LIST_CAP && roll < 50)
               pos = POS_W'($urandom_range(LIST_CAP + 1, 255));   // bad index while full
            else
               pos = POS_W'($urandom_range(0, gen_len));
         end else if (roll < 20 || gen_len == 0) begin
            pos = POS_W'(gen_len);                   // just off the end
         end else begin
            pos = POS_W'($urandom_range(0, gen_len - 1));
         end

         roll = $urandom_range(0, 99);
         case (roll % 4)
            0: val = 32'sh7fffffff;
            1: val = 32'sh80000000;
            2: val = 32'sd0;
            default: val = -32'sd1;
         endcase
         if (roll >= 12) val = $urandom;

         queue_op(op, pos, val, k == 500);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sample away from the active edge so queue and valid are settled
      while (queued_ops.size() > 0 || req_bus.valid || predicted_replies.size() > 0)
         @(negedge clock);
      repeat (TAIL_WAIT) @(negedge clock);

      if (predicted_replies.size() > 0) begin
         $display("%0t: %0d predicted replies never arrived", $time,
                  predicted_replies.size());
      end
      if (mismatches == 0 && predicted_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
